// ===== hdl/fcbf_pkg.sv =====
// Shared types and constants for the flow-controlled byte FIFO.
// Holds item kind codes, field widths and parameter defaults.
// No dependencies.
`timescale 1ns / 1ps

package fcbf_pkg;

  localparam int DEPTH_DEF     = 1024;
  localparam int MAX_BURST_DEF = 64;
  localparam int CAP_RESET     = 1024;

  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 11;
  localparam int TOTAL_W  = 32;
  localparam int BCNT_W   = 7;
  localparam int KIND_W   = 3;

  // Stream widths: input data_byte + burst_count, output status word
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = BYTE_W + 1 + CNT_W + CNT_W + TOTAL_W + TOTAL_W + 1 + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;
  localparam int IN_PAD_W    = IN_TDATA_W - BYTE_W - BCNT_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 3'd0,
    KIND_READ   = 3'd1,
    KIND_PEEK   = 3'd2,
    KIND_POP    = 3'd3,
    KIND_END    = 3'd4,
    KIND_STATUS = 3'd5
  } kind_t;

endpackage

// ===== hdl/fcbf_mem.sv =====
// Byte store for the FIFO: one write port, one read port, registered read data.
// Depends on fcbf_pkg for the byte width.
`timescale 1ns / 1ps

module fcbf_mem #(
  parameter int  DEPTH = fcbf_pkg::DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [fcbf_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [fcbf_pkg::BYTE_W-1:0] rd_data
);
  import fcbf_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/flow_controlled_byte_fifo.sv =====
// Channel  | signals                          | moves
// ---------+----------------------------------+-----------------------------------
// s_*      | s_tvalid s_tready s_tdata s_tuser | one command item in
// m_*      | m_tvalid m_tready m_tdata m_tuser | one result item out, m_tlast ends it
// cfg_*    | cfg_valid cfg_ready cfg_data      | capacity register write
//
// Write, pop, end input and status each load a single result; a write item may follow
// every cycle while the result register drains.
// Read and peek of N bytes first issue the first store read, then send one byte per
// cycle while the result register drains, paced by the single read port of the byte store.
// Reset (rst, synchronous) empties the FIFO, clears totals and sets capacity to 1024 (DEPTH if smaller).
// A stalled result holds the result register and stops input and burst progress.
// Depends on fcbf_pkg and fcbf_mem.
`timescale 1ns / 1ps

module flow_controlled_byte_fifo #(
  parameter int DEPTH     = fcbf_pkg::DEPTH_DEF,
  parameter int MAX_BURST = fcbf_pkg::MAX_BURST_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [7:0] data_byte, [14:8] burst_count, [15] zero
  input  logic [fcbf_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [2:0] kind
  input  logic [fcbf_pkg::KIND_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] out_byte, [8] accepted, [19:9] fill_count, [30:20] room_left,
  // [62:31] total_written, [94:63] total_read, [95] ended, [96] at_eof, rest zero
  output logic [fcbf_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [0] byte_valid
  output logic                             m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fcbf_pkg::CNT_W-1:0]       cfg_data
);
  import fcbf_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam logic [AW:0]      DEPTH_W = (AW+1)'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RST = (CAP_RESET > DEPTH) ? CNT_W'(DEPTH)
                                                             : CNT_W'(CAP_RESET);

  typedef enum logic {ST_IDLE, ST_BURST} state_t;

  state_t              state;
  logic [AW-1:0]       head;
  logic [CNT_W-1:0]    count;
  logic [TOTAL_W-1:0]  wr_total;
  logic [TOTAL_W-1:0]  rd_total;
  logic                ended;
  logic [CNT_W-1:0]    cap_eff;
  logic [AW-1:0]       rd_ptr;
  logic [BW-1:0]       rem;
  logic                burst_pop;

  logic [BYTE_W-1:0]   o_byte;
  logic                o_bvalid;
  logic                o_last;
  logic                o_acc;

  kind_t               kind;
  logic [BYTE_W-1:0]   data_byte;
  logic [BCNT_W-1:0]   burst_count;
  logic                accept;
  logic                out_free;
  logic [BW-1:0]       req_c;
  logic [BW-1:0]       n;
  logic                wr_ok;
  logic [AW-1:0]       tail;
  logic [AW-1:0]       head_inc;
  logic [AW-1:0]       head_pop;
  logic [AW-1:0]       ptr_inc;
  logic [CNT_W-1:0]    room;
  logic                mem_we;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [BYTE_W-1:0]   rd_data;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    wrap = (s >= DEPTH_W) ? AW'(s - DEPTH_W) : AW'(s);
  endfunction

  assign kind        = kind_t'(s_tuser);
  assign data_byte   = s_tdata[BYTE_W-1:0];
  assign burst_count = s_tdata[BYTE_W +: BCNT_W];

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // Clamp the request to the burst limit, then to what is held
  assign req_c = (int'(burst_count) > MAX_BURST) ? BW'(MAX_BURST) : BW'(burst_count);
  assign n     = (CNT_W'(req_c) < count) ? req_c : BW'(count);

  assign wr_ok    = !ended && (count < cap_eff);
  assign tail     = wrap({1'b0, head} + (AW+1)'(count));
  assign head_inc = wrap({1'b0, head} + (AW+1)'(1));
  assign head_pop = wrap({1'b0, head} + (AW+1)'(n));
  assign ptr_inc  = wrap({1'b0, rd_ptr} + (AW+1)'(1));
  assign room     = (cap_eff > count) ? cap_eff - count : '0;

  assign mem_we  = accept && (kind == KIND_WRITE) && wr_ok;
  assign rd_en   = (accept && (kind == KIND_READ || kind == KIND_PEEK) && (n != '0)) ||
                   ((state == ST_BURST) && out_free && (rem != BW'(1)));
  assign rd_addr = (state == ST_BURST) ? rd_ptr : head;

  fcbf_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (tail),
    .wr_data (data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      head     <= '0;
      count    <= '0;
      wr_total <= '0;
      rd_total <= '0;
      ended    <= 1'b0;
      cap_eff  <= CAP_RST;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cap_eff <= (int'(cfg_data) > DEPTH) ? CNT_W'(DEPTH) : cfg_data;
      end
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            o_byte   <= '0;
            o_bvalid <= 1'b0;
            o_last   <= 1'b1;
            o_acc    <= 1'b0;
            unique case (kind)
              KIND_WRITE: begin
                m_tvalid <= 1'b1;
                o_acc    <= wr_ok;
                if (wr_ok) begin
                  count    <= count + CNT_W'(1);
                  wr_total <= wr_total + TOTAL_W'(1);
                end
              end
              KIND_READ, KIND_PEEK: begin
                if (n == '0) begin
                  m_tvalid <= 1'b1;
                end else begin
                  // First store read issued now; bytes leave from the next cycle
                  rem       <= n;
                  burst_pop <= (kind == KIND_READ);
                  rd_ptr    <= head_inc;
                  state     <= ST_BURST;
                end
              end
              KIND_POP: begin
                m_tvalid <= 1'b1;
                head     <= head_pop;
                count    <= count - CNT_W'(n);
                rd_total <= rd_total + TOTAL_W'(n);
              end
              KIND_END: begin
                m_tvalid <= 1'b1;
                o_acc    <= 1'b1;
                ended    <= 1'b1;
              end
              default: begin
                m_tvalid <= 1'b1;
              end
            endcase
          end
        end
        ST_BURST: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            o_byte   <= rd_data;
            o_bvalid <= 1'b1;
            o_last   <= (rem == BW'(1));
            o_acc    <= 1'b0;
            rem      <= rem - BW'(1);
            if (burst_pop) begin
              head     <= head_inc;
              count    <= count - CNT_W'(1);
              rd_total <= rd_total + TOTAL_W'(1);
            end
            if (rem == BW'(1)) begin
              state <= ST_IDLE;
            end else begin
              rd_ptr <= ptr_inc;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Status fields follow the live state: it moves when a result is loaded, and room_left on a capacity write
  assign m_tdata = {{OUT_PAD_W{1'b0}}, (ended && (count == '0)), ended,
                    rd_total, wr_total, room, count, o_acc, o_byte};
  assign m_tuser = o_bvalid;
  assign m_tlast = o_last;

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= DEPTH)
    else $error("fill level beyond store depth");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(head) < DEPTH)
    else $error("head index beyond store depth");

  a_burst_covered: assert property (@(posedge clk) disable iff (rst)
    (state == ST_BURST) |-> ((rem != '0) && (CNT_W'(rem) <= count)))
    else $error("burst outruns held bytes");

  a_burst_pop_moves_head: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_BURST) && burst_pop && out_free) |=> (head == $past(head_inc)))
    else $error("read burst did not advance head");

endmodule
